FILE: src/fsi_pkg.sv
// ----------------------------------------------------------------------------
// fsi_pkg
// Types, codes and constants shared by the frame sample interpolator.
// ----------------------------------------------------------------------------
package fsi_pkg;

  localparam int FSI_TABLE_DEPTH = 256;
  localparam int FSI_PREFIX_BYTES = 2;
  localparam int FSI_PROD_W = 49;
  localparam int FSI_CNT_W = 6;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_RSVD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_REJECT = 3'd1,
    ST_CLOSED = 3'd2,
    ST_FRAME  = 3'd3,
    ST_ENDED  = 3'd4,
    ST_IGNORE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_LOAD = 2'd0,
    PH_WALK = 2'd1,
    PH_END  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOSE_RD,
    S_CLOSE_CHK,
    S_CLOSE_WR,
    S_FR_RD,
    S_FR_CUR,
    S_WALK,
    S_WALK_NXT,
    S_LEN,
    S_MUL,
    S_DIV,
    S_UPD,
    S_DONE
  } fsm_t;

  typedef enum logic {
    REG_DATA_SIZE     = 1'b0,
    REG_TOTAL_SAMPLES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] entry_position;
    logic [31:0] entry_offset;
    logic [15:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] frame_samples;
    logic [31:0] frame_offset;
  } out_item_t;

  function automatic logic precedes(input logic [31:0] ao, input logic [31:0] ap,
                                    input logic [31:0] bo, input logic [31:0] bp);
    return (ao < bo) && (ap <= bp);
  endfunction

endpackage

FILE: src/fsi_stream_if.sv
// ----------------------------------------------------------------------------
// fsi_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface fsi_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/frame_sample_interpolator.sv
// ----------------------------------------------------------------------------
// frame_sample_interpolator
// Seek table builder and frame sample interpolator.
//
// Usage: item is a valid/ready sink of in_item_t beats, result a valid/ready
// source of out_item_t beats; every item gives exactly one result beat.
// cfg_we/cfg_index/cfg_data write data_size (0) and total_samples (1).
// An add-entry beat goes straight to the result stage. A close beat pops table
// entries that do not precede the end point, then writes it. A frame beat walks
// the table and then runs the bit-serial divide (one quotient bit per cycle).
// item.ready is high only while the sequencer is idle.
// The result register lets the next item start while a result waits; if the
// receiver stalls, the sequencer holds its finished result until taken.
// Reset (rst, synchronous) empties the table to the single entry (0,0),
// clears the registers and returns to the table loading phase. Table RAM
// contents are not cleared; entry zero reads as (0,0) until rewritten.
// ----------------------------------------------------------------------------
module frame_sample_interpolator
  import fsi_pkg::*;
#(
  parameter int TABLE_DEPTH = FSI_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  fsi_stream_if.sink   item,
  fsi_stream_if.source result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  fsm_t   state, state_next;
  phase_t phase;

  logic [31:0] data_size, total_samples;
  logic [CW-1:0] entry_count;
  logic [AW-1:0] read_index;
  logic [63:0] delta_bytes;
  logic [31:0] delta_samples;
  logic [31:0] stream_position;
  logic [31:0] last_off, last_pos;
  logic        wr0;
  logic        rd0;

  in_item_t    cur_item;
  logic [31:0] rest;
  logic [31:0] cur_off, cur_pos;
  logic [16:0] total;
  logic [FSI_PROD_W-1:0] quo;
  logic [64:0] rem;
  logic [FSI_CNT_W-1:0] cnt;
  out_item_t   res;
  out_item_t   out_reg;
  logic        out_valid;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata, rd_entry;
  logic [AW-1:0] ri_inc;
  logic [64:0]   trial;

  fsi_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = rd0 ? 64'd0 : ram_rdata;
  assign ri_inc = read_index + AW'(1);
  assign trial = {rem[63:0], quo[FSI_PROD_W-1]};

  assign item.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_waddr = entry_count[AW-1:0];
    ram_wdata = {data_size, total_samples};
    ram_raddr = read_index;
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          unique case (item.data.action)
            ACT_ADD:   state_next = S_DONE;
            ACT_CLOSE: state_next = (phase == PH_LOAD) ? S_CLOSE_RD : S_DONE;
            ACT_FRAME: state_next = (phase == PH_WALK) ? S_FR_RD : S_DONE;
            default:   state_next = S_DONE;
          endcase
          if (item.data.action == ACT_ADD && phase == PH_LOAD &&
              entry_count < CW'(TABLE_DEPTH - 1) &&
              precedes(last_off, last_pos, item.data.entry_offset,
                       item.data.entry_position)) begin
            ram_we = 1'b1;
            ram_wdata = {item.data.entry_offset, item.data.entry_position};
          end
        end
      end
      S_CLOSE_RD: begin
        ram_raddr = entry_count[AW-1:0] - AW'(1);
        state_next = (entry_count == '0) ? S_CLOSE_WR : S_CLOSE_CHK;
      end
      S_CLOSE_CHK: begin
        state_next = precedes(rd_entry[63:32], rd_entry[31:0], data_size, total_samples)
                     ? S_CLOSE_WR : S_CLOSE_RD;
      end
      S_CLOSE_WR: begin
        ram_we = 1'b1;
        state_next = S_DONE;
      end
      S_FR_RD: begin
        ram_raddr = read_index;
        state_next = (rest <= 32'd2) ? S_DONE : S_FR_CUR;
      end
      S_FR_CUR: state_next = S_WALK;
      S_WALK: begin
        ram_raddr = ri_inc;
        if ((CW'(read_index) < entry_count) && (stream_position >= cur_off) &&
            (CW'(read_index) + CW'(1) < entry_count)) begin
          state_next = S_WALK_NXT;
        end else begin
          state_next = S_LEN;
        end
      end
      S_WALK_NXT: state_next = S_WALK;
      S_LEN: begin
        if (cur_item.frame_length == 16'd0 ||
            32'(cur_item.frame_length) > rest - 32'd2) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = (delta_bytes == 64'd0) ? S_UPD : S_DIV;
      S_DIV: state_next = (cnt == FSI_CNT_W'(FSI_PROD_W - 1)) ? S_UPD : S_DIV;
      S_UPD: state_next = S_DONE;
      S_DONE: state_next = (!out_valid || result.ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOAD;
      data_size <= '0;
      total_samples <= '0;
      entry_count <= CW'(1);
      read_index <= '0;
      delta_bytes <= '0;
      delta_samples <= '0;
      stream_position <= '0;
      last_off <= '0;
      last_pos <= '0;
      wr0 <= 1'b0;
      rd0 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd0 <= (ram_raddr == '0) && !wr0;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_DATA_SIZE:     data_size <= cfg_data;
          REG_TOTAL_SAMPLES: total_samples <= cfg_data;
          default: ;
        endcase
      end
      if (result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            cur_item <= item.data;
            rest <= (data_size > stream_position) ? data_size - stream_position : 32'd0;
            res.frame_samples <= 64'd0;
            res.frame_offset <= 32'd0;
            if (item.data.action == ACT_ADD && phase == PH_LOAD) begin
              if (entry_count < CW'(TABLE_DEPTH - 1) &&
                  precedes(last_off, last_pos, item.data.entry_offset,
                           item.data.entry_position)) begin
                entry_count <= entry_count + CW'(1);
                last_off <= item.data.entry_offset;
                last_pos <= item.data.entry_position;
                res.status <= ST_STORED;
              end else begin
                res.status <= ST_REJECT;
              end
            end else begin
              res.status <= ST_IGNORE;
            end
          end
        end
        S_CLOSE_CHK: begin
          if (!precedes(rd_entry[63:32], rd_entry[31:0], data_size, total_samples)) begin
            entry_count <= entry_count - CW'(1);
          end
        end
        S_CLOSE_WR: begin
          if (entry_count == '0) begin
            wr0 <= 1'b1;
          end
          entry_count <= entry_count + CW'(1);
          read_index <= '0;
          phase <= PH_WALK;
          res.status <= ST_CLOSED;
        end
        S_FR_RD: begin
          res.frame_offset <= stream_position;
          if (rest <= 32'd2) begin
            phase <= PH_END;
            res.status <= ST_ENDED;
          end
        end
        S_FR_CUR: begin
          cur_off <= rd_entry[63:32];
          cur_pos <= rd_entry[31:0];
        end
        S_WALK_NXT: begin
          delta_bytes <= {32'd0, rd_entry[63:32]} - {32'd0, cur_off};
          delta_samples <= rd_entry[31:0] - cur_pos;
          cur_off <= rd_entry[63:32];
          cur_pos <= rd_entry[31:0];
          read_index <= ri_inc;
        end
        S_LEN: begin
          total <= 17'(cur_item.frame_length) + 17'(FSI_PREFIX_BYTES);
          if (cur_item.frame_length == 16'd0 ||
              32'(cur_item.frame_length) > rest - 32'd2) begin
            phase <= PH_END;
            res.status <= ST_ENDED;
          end
        end
        S_MUL: begin
          quo <= FSI_PROD_W'(total) * FSI_PROD_W'(delta_samples);
          rem <= '0;
          cnt <= '0;
        end
        S_DIV: begin
          cnt <= cnt + FSI_CNT_W'(1);
          if (trial >= {1'b0, delta_bytes}) begin
            rem <= trial - {1'b0, delta_bytes};
            quo <= {quo[FSI_PROD_W-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[FSI_PROD_W-2:0], 1'b0};
          end
        end
        S_UPD: begin
          if (delta_bytes == 64'd0) begin
            res.frame_samples <= 64'd0;
          end else begin
            res.frame_samples <= 64'(quo);
            delta_samples <= delta_samples - quo[31:0];
          end
          delta_bytes <= delta_bytes - 64'(total);
          stream_position <= stream_position + 32'(total);
          res.status <= ST_FRAME;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_reg <= res;
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/fsi_ram.sv
// ----------------------------------------------------------------------------
// fsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/fsi_checker.sv
// ----------------------------------------------------------------------------
// fsi_checker
// Port-level checks for the frame sample interpolator.
// ----------------------------------------------------------------------------
module fsi_checker
  import fsi_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [63:0] out_samples
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after an accepted beat");

  a_samples_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_FRAME) |-> (out_samples == 64'd0))
    else $error("nonzero samples on a non-frame result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

endmodule

bind frame_sample_interpolator fsi_checker u_fsi_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_status  (result.data.status),
  .out_samples (result.data.frame_samples)
);
